/* hdl/kts_pkg.sv */
package kts_pkg;

   localparam int DATA_W     = 32;
   localparam int PATH_W     = 48;
   localparam int VAR_W      = 32;
   localparam int VAR_FRAC   = 24;
   localparam int GAIN_W     = VAR_FRAC + 1;
   localparam int NUM_AXES   = 3;
   localparam int AXIS_W     = 2;
   localparam int CSR_ADDR_W = 3;

   localparam logic [VAR_W-1:0] VAR_ONE           = 32'h0100_0000;
   localparam logic [31:0]      PROCESS_NOISE_RST = 32'd67109;
   localparam logic [31:0]      MEASURE_NOISE_RST = 32'd4194304;

   // register index, taken from paddr[2]
   localparam logic CSR_PROCESS_NOISE = 1'b0;
   localparam logic CSR_MEASURE_NOISE = 1'b1;

   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_RESID_LO = 2'd0;
   localparam mul_sel_type MUL_RESID_HI = 2'd1;
   localparam mul_sel_type MUL_VARIANCE = 2'd2;

   typedef struct packed {
      logic              load;
      logic              init_state;
      logic              calc_pp;
      logic              calc_den;
      logic              load_gain;
      mul_sel_type       mul_sel;
      logic              hold_lo;
      logic              upd_smooth;
      logic              upd_var;
      logic [AXIS_W-1:0] axis;
      logic              load_out;
   } kts_cmd_type;

   typedef struct packed {
      logic div_done;
   } kts_status_type;

endpackage

/* hdl/kts_if.sv */
interface kts_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] motion_x;
   logic signed [31:0] motion_y;
   logic signed [31:0] motion_angle;

   modport source (output valid, output motion_x, output motion_y, output motion_angle,
                   input ready);
   modport sink   (input valid, input motion_x, input motion_y, input motion_angle,
                   output ready);
endinterface

interface kts_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] corrected_x;
   logic signed [31:0] corrected_y;
   logic signed [31:0] corrected_angle;

   modport source (output valid, output corrected_x, output corrected_y,
                   output corrected_angle, input ready);
   modport sink   (input valid, input corrected_x, input corrected_y,
                   input corrected_angle, output ready);
endinterface

/* hdl/kts_csr.sv */
module kts_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [kts_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output logic [31:0]                      process_noise,
   output logic [31:0]                      measure_noise
);

   logic [31:0] process_noise_ff;
   logic [31:0] measure_noise_ff;
   logic        wr_en;
   logic        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff <= kts_pkg::PROCESS_NOISE_RST;
         measure_noise_ff <= kts_pkg::MEASURE_NOISE_RST;
      end else if (wr_en) begin
         case (reg_idx)
            kts_pkg::CSR_PROCESS_NOISE: process_noise_ff <= pwdata;
            kts_pkg::CSR_MEASURE_NOISE: measure_noise_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         kts_pkg::CSR_PROCESS_NOISE: prdata = process_noise_ff;
         kts_pkg::CSR_MEASURE_NOISE: prdata = measure_noise_ff;
         default:                    prdata = '0;
      endcase
   end

   assign process_noise = process_noise_ff;
   assign measure_noise = measure_noise_ff;

endmodule

/* hdl/kts_div.sv */
// Restoring divider: quotient = floor(numer * 2^24 / denom), numer <= denom.
// One quotient bit a cycle, most significant first; the first step takes no shift.
module kts_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 numer,
   input  logic [32:0]                 denom,
   output logic                        done,
   output logic [kts_pkg::GAIN_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(kts_pkg::GAIN_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(kts_pkg::GAIN_W - 1);

   logic                        busy_ff, busy_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [32:0]                 rem_ff, rem_in;
   logic [kts_pkg::GAIN_W-1:0]  quo_ff, quo_in;
   logic [33:0]                 trial;
   logic                        ge;

   always_comb begin
      trial   = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      ge      = trial >= {1'b0, denom};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, numer};
      end else if (busy_ff) begin
         rem_in = ge ? 33'(trial - {1'b0, denom}) : trial[32:0];
         quo_in = {quo_ff[kts_pkg::GAIN_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = busy_ff && (cnt_ff == LAST_STEP);
   assign quotient = quo_ff;

endmodule

/* hdl/kts_dp.sv */
module kts_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  kts_pkg::kts_cmd_type     cmd,
   output kts_pkg::kts_status_type  status,
   input  logic signed [31:0]       motion_x,
   input  logic signed [31:0]       motion_y,
   input  logic signed [31:0]       motion_angle,
   input  logic [31:0]              process_noise,
   input  logic [31:0]              measure_noise,
   output logic signed [31:0]       corrected_x,
   output logic signed [31:0]       corrected_y,
   output logic signed [31:0]       corrected_angle
);

   localparam int NA = kts_pkg::NUM_AXES;

   logic signed [47:0]               path_ff   [NA];
   logic signed [47:0]               smooth_ff [NA];
   logic signed [31:0]               motion_ff [NA];
   logic signed [31:0]               out_ff    [NA];
   logic [31:0]                      var_ff;
   logic [31:0]                      pp_ff;
   logic [32:0]                      den_ff;
   logic [kts_pkg::GAIN_W-1:0]       k_ff;
   logic signed [59:0]               prod_ff;
   logic [25:0]                      lo_part_ff;

   logic signed [31:0]               motion_in [NA];
   logic signed [47:0]               path_in   [NA];
   logic signed [31:0]               out_in    [NA];
   logic [32:0]                      pp_sum;
   logic [31:0]                      pp_in;
   logic [32:0]                      den_in;
   logic [kts_pkg::GAIN_W-1:0]       quotient;
   logic [kts_pkg::GAIN_W-1:0]       k_comp;
   logic signed [48:0]               resid;
   logic signed [25:0]               mul_a;
   logic signed [33:0]               mul_b;
   logic [49:0]                      lo_rnd;
   logic [50:0]                      smooth_sum;
   logic signed [47:0]               smooth_in;
   logic [57:0]                      var_rnd;

   function automatic logic signed [47:0] sat_path(input logic [50:0] v);
      if (v[50:47] == {4{v[47]}}) begin
         return v[47:0];
      end else begin
         return v[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end
   endfunction

   function automatic logic signed [31:0] sat_word(input logic [49:0] v);
      if (v[49:31] == {19{v[31]}}) begin
         return v[31:0];
      end else begin
         return v[49] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end
   endfunction

   assign motion_in[0] = motion_x;
   assign motion_in[1] = motion_y;
   assign motion_in[2] = motion_angle;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         path_in[i] = sat_path({{3{path_ff[i][47]}}, path_ff[i]}
                               + {{19{motion_in[i][31]}}, motion_in[i]});
         out_in[i]  = sat_word({{18{motion_ff[i][31]}}, motion_ff[i]}
                               + {{2{smooth_ff[i][47]}}, smooth_ff[i]}
                               - {{2{path_ff[i][47]}}, path_ff[i]});
      end
   end

   // predicted variance saturates at all ones
   assign pp_sum = {1'b0, var_ff} + {1'b0, process_noise};
   assign pp_in  = pp_sum[32] ? '1 : pp_sum[31:0];
   assign den_in = {1'b0, pp_ff} + {1'b0, measure_noise};

   kts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.calc_den),
      .numer    (pp_ff),
      .denom    (den_ff),
      .done     (status.div_done),
      .quotient (quotient)
   );

   assign k_comp = kts_pkg::VAR_ONE[kts_pkg::GAIN_W-1:0] - k_ff;
   assign resid  = {path_ff[cmd.axis][47], path_ff[cmd.axis]}
                 - {smooth_ff[cmd.axis][47], smooth_ff[cmd.axis]};

   always_comb begin
      case (cmd.mul_sel)
         kts_pkg::MUL_RESID_LO: begin
            mul_a = {1'b0, k_ff};
            mul_b = {10'b0, resid[23:0]};
         end
         kts_pkg::MUL_RESID_HI: begin
            mul_a = {1'b0, k_ff};
            mul_b = {{9{resid[48]}}, resid[48:24]};
         end
         kts_pkg::MUL_VARIANCE: begin
            mul_a = {1'b0, k_comp};
            mul_b = {2'b0, pp_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // round half up on the low partial product, then add the high one unshifted
   assign lo_rnd     = prod_ff[49:0] + 50'h80_0000;
   assign smooth_sum = {{3{smooth_ff[cmd.axis][47]}}, smooth_ff[cmd.axis]}
                     + {prod_ff[49], prod_ff[49:0]}
                     + {25'b0, lo_part_ff};
   assign smooth_in  = sat_path(smooth_sum);
   assign var_rnd    = prod_ff[57:0] + 58'h80_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NA; i++) begin
            path_ff[i]   <= '0;
            smooth_ff[i] <= '0;
         end
         var_ff <= kts_pkg::VAR_ONE;
      end else begin
         if (cmd.load) begin
            for (int i = 0; i < NA; i++) begin
               path_ff[i] <= path_in[i];
            end
         end
         if (cmd.init_state) begin
            for (int i = 0; i < NA; i++) begin
               smooth_ff[i] <= '0;
            end
            var_ff <= kts_pkg::VAR_ONE;
         end
         if (cmd.upd_smooth) begin
            smooth_ff[cmd.axis] <= smooth_in;
         end
         if (cmd.upd_var) begin
            var_ff <= var_rnd[55:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load) begin
         for (int i = 0; i < NA; i++) begin
            motion_ff[i] <= motion_in[i];
         end
      end
      if (cmd.calc_pp) begin
         pp_ff <= pp_in;
      end
      if (cmd.calc_den) begin
         den_ff <= den_in;
      end
      if (cmd.load_gain) begin
         k_ff <= (den_ff == '0) ? '0 : quotient;
      end
      if (cmd.hold_lo) begin
         lo_part_ff <= lo_rnd[49:24];
      end
      if (cmd.load_out) begin
         for (int i = 0; i < NA; i++) begin
            out_ff[i] <= out_in[i];
         end
      end
   end

   assign corrected_x     = out_ff[0];
   assign corrected_y     = out_ff[1];
   assign corrected_angle = out_ff[2];

endmodule

/* hdl/kts_ctrl.sv */
module kts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kts_pkg::kts_cmd_type     cmd,
   input  kts_pkg::kts_status_type  status
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INIT   = 4'd1;
   localparam logic [3:0] S_PP     = 4'd2;
   localparam logic [3:0] S_DEN    = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_GAIN   = 4'd5;
   localparam logic [3:0] S_MLO    = 4'd6;
   localparam logic [3:0] S_MHI    = 4'd7;
   localparam logic [3:0] S_ACC    = 4'd8;
   localparam logic [3:0] S_MVAR   = 4'd9;
   localparam logic [3:0] S_VAR    = 4'd10;
   localparam logic [3:0] S_FINISH = 4'd11;

   localparam logic [kts_pkg::AXIS_W-1:0] LAST_AXIS = kts_pkg::AXIS_W'(kts_pkg::NUM_AXES - 1);

   logic [3:0]                  state_ff, state_in;
   logic [kts_pkg::AXIS_W-1:0]  axis_ff, axis_in;
   logic                        started_ff, started_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      started_in = started_ff;
      cmd        = '0;
      cmd.axis   = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = started_ff ? S_PP : S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_state = 1'b1;
            started_in     = 1'b1;
            state_in       = S_FINISH;
         end
         S_PP: begin
            cmd.calc_pp = 1'b1;
            state_in    = S_DEN;
         end
         S_DEN: begin
            cmd.calc_den = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.load_gain = 1'b1;
            axis_in       = '0;
            state_in      = S_MLO;
         end
         S_MLO: begin
            cmd.mul_sel = kts_pkg::MUL_RESID_LO;
            state_in    = S_MHI;
         end
         S_MHI: begin
            cmd.mul_sel = kts_pkg::MUL_RESID_HI;
            cmd.hold_lo = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.upd_smooth = 1'b1;
            if (axis_ff == LAST_AXIS) begin
               state_in = S_MVAR;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_MLO;
            end
         end
         S_MVAR: begin
            cmd.mul_sel = kts_pkg::MUL_VARIANCE;
            state_in    = S_VAR;
         end
         S_VAR: begin
            cmd.upd_var = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_first_frame_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !started_ff) |=> (state_ff == S_INIT))
      else $error("first frame did not take the initialisation path");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide wait");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before transfer");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_smooth |-> (axis_ff <= LAST_AXIS))
      else $error("axis counter out of range");

   a_result_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not presented after load");
`endif

endmodule

/* hdl/kalman_trajectory_smoother_top.sv */
// Trajectory smoother for video stabilisation.
// req_ch carries one frame's motion (motion_x, motion_y, motion_angle, signed Q16.16);
// rsp_ch returns one stabilising correction per frame (corrected_*, saturated).
// Both channels transfer on a rising edge with valid and ready high.
// The csr_ APB port holds process_noise (offset 0) and measure_noise (offset 4),
// both unsigned Q8.24; write them only while no frame is in flight.
// The first frame after reset only initialises estimate and variance before its
// result is loaded; every later frame runs the filter first. One frame is in work
// at a time: req_ch.ready rises again once the result is loaded, so the next frame
// is not taken before the last one is through. The frame time is set by the
// 25-step serial gain divider plus seven passes through the shared multiplier.
// The result waits in an output register, so the next frame is accepted while the
// receiver stalls; the block then holds its finished result until rsp_ch.ready.
// Reset (synchronous) clears trajectory and estimate, sets variance to 1.0 and
// restores the default noise values; the next frame restarts the filter.
module kalman_trajectory_smoother_top (
   input  logic                            clock,
   input  logic                            reset,
   kts_req_if.sink                         req_ch,
   kts_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [kts_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [31:0]              process_noise;
   logic [31:0]              measure_noise;
   kts_pkg::kts_cmd_type     cmd;
   kts_pkg::kts_status_type  status;

   kts_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .process_noise (process_noise),
      .measure_noise (measure_noise)
   );

   kts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   kts_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .motion_x        (req_ch.motion_x),
      .motion_y        (req_ch.motion_y),
      .motion_angle    (req_ch.motion_angle),
      .process_noise   (process_noise),
      .measure_noise   (measure_noise),
      .corrected_x     (rsp_ch.corrected_x),
      .corrected_y     (rsp_ch.corrected_y),
      .corrected_angle (rsp_ch.corrected_angle)
   );

endmodule

/* tb/kalman_trajectory_smoother_top_tb.sv */
`timescale 1ns / 1ps

module kalman_trajectory_smoother_top_tb;

   localparam int     STALL_LIMIT     = 5000;
   localparam int     HOLD_OFF_CYCLES = 600;
   localparam int     PHASE_FRAMES    = 400;
   localparam longint PATH_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint PATH_MIN        = -PATH_MAX - 1;
   localparam longint OUT_MAX         = 64'sh0000_0000_7FFF_FFFF;
   localparam longint OUT_MIN         = -OUT_MAX - 1;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] angle;
   } correction_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [kts_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   kts_req_if req_if ();
   kts_rsp_if rsp_if ();

   kalman_trajectory_smoother_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // smoother state as the block should hold it
   longint      trajectory [3];
   longint      estimate [3];
   logic [31:0] variance;
   bit          first_seen;
   logic [31:0] q_noise;
   logic [31:0] r_noise;

   correction_type pending_corrections [$];
   int          mismatch_count;
   bit          quiet_phase;
   bit          hold_off_go;
   int          hold_left;
   int          stall_cycles;

   function automatic longint clamp48(input longint v);
      if (v > PATH_MAX) return PATH_MAX;
      if (v < PATH_MIN) return PATH_MIN;
      return v;
   endfunction

   // advance the trajectory and filter by one frame, return its corrections
   function automatic correction_type smooth_frame(input logic signed [31:0] mx,
                                                   input logic signed [31:0] my,
                                                   input logic signed [31:0] ma);
      longint             motion [3];
      longint             resid;
      longint             hi;
      longint             step;
      longint             total;
      longint unsigned    pp;
      longint unsigned    den;
      longint unsigned    gain;
      longint unsigned    lo;
      longint unsigned    lo_part;
      logic signed [31:0] fix [3];
      correction_type     c;

      motion[0] = mx;
      motion[1] = my;
      motion[2] = ma;
      for (int i = 0; i < 3; i++)
         trajectory[i] = clamp48(trajectory[i] + motion[i]);

      if (!first_seen) begin
         for (int i = 0; i < 3; i++) estimate[i] = 0;
         variance   = kts_pkg::VAR_ONE;
         first_seen = 1'b1;
      end else begin
         pp = variance;
         pp = pp + q_noise;
         if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
         den  = pp + r_noise;
         gain = (den != 0) ? (pp << kts_pkg::VAR_FRAC) / den : 0;
         if (gain > kts_pkg::VAR_ONE) gain = kts_pkg::VAR_ONE;
         for (int i = 0; i < 3; i++) begin
            // split the residual so the rounding matches a half-up gain product
            resid   = trajectory[i] - estimate[i];
            lo      = resid & 64'h00FF_FFFF;
            hi      = resid >>> kts_pkg::VAR_FRAC;
            lo_part = (gain * lo + (64'd1 << (kts_pkg::VAR_FRAC - 1))) >> kts_pkg::VAR_FRAC;
            step    = $signed(gain) * hi + $signed(lo_part);
            estimate[i] = clamp48(estimate[i] + step);
         end
         variance = 32'(((kts_pkg::VAR_ONE - gain) * pp
                         + (64'd1 << (kts_pkg::VAR_FRAC - 1))) >> kts_pkg::VAR_FRAC);
      end

      for (int i = 0; i < 3; i++) begin
         total = motion[i] + (estimate[i] - trajectory[i]);
         if (total > OUT_MAX) total = OUT_MAX;
         if (total < OUT_MIN) total = OUT_MIN;
         fix[i] = total[31:0];
      end
      c.x     = fix[0];
      c.y     = fix[1];
      c.angle = fix[2];
      return c;
   endfunction

   function automatic logic signed [31:0] pick_motion(input logic signed [31:0] drift);
      logic signed [31:0] jitter;
      jitter = $urandom_range(0, 32'h0002_0000);
      case ($urandom_range(19))
         0:       return $urandom;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh8000_0000;
         3:       return '0;
         default: return drift + jitter - 32'sh0001_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_noise();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h0100_0000);
         2:       return $urandom_range(0, 1023);
         default: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      endcase
   endfunction

   task automatic send_frame(input logic signed [31:0] mx,
                             input logic signed [31:0] my,
                             input logic signed [31:0] ma);
      int gap;
      if (!quiet_phase && $urandom_range(99) < 8) begin
         gap = $urandom_range(1, 48);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.motion_x     <= mx;
      req_if.motion_y     <= my;
      req_if.motion_angle <= ma;
      do @(posedge clock); while (!req_if.ready);
      pending_corrections = {pending_corrections, smooth_frame(mx, my, ma)};
   endtask

   // drop valid in the step of the last transfer, then wait for every correction
   task automatic drain_frames();
      req_if.valid <= 1'b0;
      while (pending_corrections.size() != 0) @(posedge clock);
   endtask

   task automatic program_noise(input logic [31:0] q, input logic [31:0] r);
      logic        reg_idx;
      logic [31:0] value;
      for (int i = 0; i < 2; i++) begin
         reg_idx = (i == 0) ? kts_pkg::CSR_PROCESS_NOISE : kts_pkg::CSR_MEASURE_NOISE;
         value   = (reg_idx == kts_pkg::CSR_PROCESS_NOISE) ? q : r;
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {reg_idx, 2'b00};
         csr_pwdata  <= value;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (reg_idx == kts_pkg::CSR_PROCESS_NOISE) q_noise = value;
         else r_noise = value;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic flag_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endtask

   task automatic test_first_frame_extremes();
      send_frame(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
      send_frame(32'sh0000_0001, -32'sh0000_0001, 32'sh0001_0000);
      send_frame(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_frame(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_frame(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_frame(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_frame(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh0000_0001);
      send_frame(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
      drain_frames();
   endtask

   // noise at zero and all ones in each pairing; zero noise drives the gain to one and then the denominator to zero
   task automatic test_noise_extremes();
      logic [31:0] q_set [4];
      logic [31:0] r_set [4];
      q_set = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};
      r_set = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
      for (int s = 0; s < 4; s++) begin
         program_noise(q_set[s], r_set[s]);
         for (int n = 0; n < 4; n++)
            send_frame(32'sh0003_8000 * n, -32'sh0001_4000, 32'sh0000_0C00 - n);
         drain_frames();
      end
   endtask

   task automatic test_output_backpressure();
      program_noise(kts_pkg::PROCESS_NOISE_RST, kts_pkg::MEASURE_NOISE_RST);
      @(negedge clock) hold_off_go = 1'b1;
      @(posedge clock);
      for (int n = 0; n < 24; n++)
         send_frame(pick_motion('0), pick_motion('0), pick_motion('0));
      drain_frames();
   endtask

   task automatic test_random_frames();
      logic signed [31:0] drift;
      drift = '0;
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0)
            program_noise(kts_pkg::PROCESS_NOISE_RST, kts_pkg::MEASURE_NOISE_RST);
         else program_noise(pick_noise(), pick_noise());
         quiet_phase = (phase == 0);
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            if (n % 50 == 0) drift = $urandom_range(0, 32'h0008_0000) - 32'sh0004_0000;
            send_frame(pick_motion(drift), pick_motion(drift), pick_motion(drift));
         end
         drain_frames();
      end
      quiet_phase = 1'b0;
   endtask

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_off_go) begin
         hold_off_go = 1'b0;
         hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= quiet_phase || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      correction_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_corrections.size() == 0) begin
            flag_mismatch("unexpected correction", 'x, rsp_if.corrected_x);
         end else begin
            want = pending_corrections.pop_front();
            if (rsp_if.corrected_x !== want.x)
               flag_mismatch("corrected_x", want.x, rsp_if.corrected_x);
            if (rsp_if.corrected_y !== want.y)
               flag_mismatch("corrected_y", want.y, rsp_if.corrected_y);
            if (rsp_if.corrected_angle !== want.angle)
               flag_mismatch("corrected_angle", want.angle, rsp_if.corrected_angle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.motion_x     = '0;
      req_if.motion_y     = '0;
      req_if.motion_angle = '0;
      rsp_if.ready        = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      stall_cycles        = 0;
      mismatch_count      = 0;
      quiet_phase         = 1'b0;
      hold_off_go         = 1'b0;
      hold_left           = 0;
      for (int i = 0; i < 3; i++) begin
         trajectory[i] = 0;
         estimate[i]   = 0;
      end
      variance   = kts_pkg::VAR_ONE;
      first_seen = 1'b0;
      q_noise    = kts_pkg::PROCESS_NOISE_RST;
      r_noise    = kts_pkg::MEASURE_NOISE_RST;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_first_frame_extremes();
      test_noise_extremes();
      test_output_backpressure();
      test_random_frames();

      drain_frames();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_corrections.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
